>>> design/lru_page_tracker_macros.svh
// Assertion macros used by the tracker top level.
`ifndef LRU_PAGE_TRACKER_MACROS_SVH
`define LRU_PAGE_TRACKER_MACROS_SVH

// expr must hold at every rising clock edge out of reset
`define LPT_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("tracker invariant violated");

// cons must hold in the cycle after ante
`define LPT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tracker sequencing violated");

`endif

>>> design/lpt_pkg.sv
// Types and fixed constants of the LRU page tracker.
package lpt_pkg;

	localparam int CFG_W = 5;
	localparam int OCC_W = 5;
	localparam logic [CFG_W-1:0] RESET_ACTIVE = 5'd10;

	// broadcast from the top level to every cell
	typedef struct packed {
		logic step;
		logic hit;
	} lpt_ctrl_t;

endpackage

>>> design/lpt_ifs.sv
// Request channel interfaces of the LRU page tracker.
interface lpt_fetch_if #(parameter int PAGE_BITS = 20);
	logic                 valid;
	logic                 ready;
	logic [PAGE_BITS-1:0] page_number;

	modport source (output valid, output page_number, input ready);
	modport sink (input valid, input page_number, output ready);
endinterface

interface lpt_result_if #(parameter int PAGE_BITS = 20);
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic                 evicted_valid;
	logic [PAGE_BITS-1:0] evicted_page;
	logic [4:0]           occupancy;

	modport source (output valid, output hit, output evicted_valid, output evicted_page,
		output occupancy, input ready);
	modport sink (input valid, input hit, input evicted_valid, input evicted_page,
		input occupancy, output ready);
endinterface

interface lpt_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] active_entries;

	modport source (output valid, output active_entries, input ready);
	modport sink (input valid, input active_entries, output ready);
endinterface

>>> design/lpt_cell.sv
// One slot of the recency stack: holds a page and takes its upper neighbor's on a shift.
module lpt_cell import lpt_pkg::*; #(
	parameter int PAGE_BITS = 20,
	parameter int CW = 5,
	parameter logic [CW-1:0] IDX = '0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lpt_ctrl_t            ctrl,
	input  logic [PAGE_BITS-1:0] page,
	input  logic [CW-1:0]        stop,
	input  logic                 prev_valid,
	input  logic [PAGE_BITS-1:0] prev_tag,
	input  logic                 clear_above,
	output logic                 valid,
	output logic [PAGE_BITS-1:0] tag,
	output logic                 match,
	output logic                 clear_below
);

	logic                 valid_q;
	logic [PAGE_BITS-1:0] tag_q;
	logic                 shift;

	assign match       = valid_q && (tag_q == page);
	assign clear_below = clear_above && !match;
	// hit: every slot down to the matching one moves; miss: slots down to stop move
	assign shift = ctrl.step && (ctrl.hit ? clear_above : (IDX <= stop));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			tag_q <= prev_tag;
		end
	end

	assign valid = valid_q;
	assign tag   = tag_q;

endmodule

>>> design/lru_page_tracker.sv
// LRU page tracker: a row of recency cells, most recent page in cell 0.
// The result of a request is registered in the cycle after the request is accepted.
// Throughput: one request per cycle while results are taken; the tag compare
// across all cells and the one-place shift of the row both finish in that cycle.
// Reset clears all valid bits and the resident count; active_entries returns to 10.
// No clearing pass follows reset; requests are taken in the first cycle after it.
module lru_page_tracker import lpt_pkg::*; #(
	parameter int CAPACITY = 16,
	parameter int PAGE_BITS = 20
) (
	input logic            clk,
	input logic            arst_n,
	lpt_fetch_if.sink      fetch,
	lpt_result_if.source   result,
	lpt_cfg_if.sink        cfg
);

`include "lru_page_tracker_macros.svh"

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int AW = (CW > CFG_W) ? CW : CFG_W;

	logic [CFG_W-1:0]     active_entries_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        count_next;
	logic [CW-1:0]        limit;
	logic [CW-1:0]        stop;
	logic                 full;
	logic                 accept;
	logic                 hit_c;
	lpt_ctrl_t            ctrl;

	logic [CAPACITY-1:0]  cell_valid;
	logic [PAGE_BITS-1:0] cell_tag [CAPACITY];
	logic [CAPACITY-1:0]  cell_match;
	logic [CAPACITY:0]    clear_chain;

	logic                 out_valid_q;
	logic                 hit_q;
	logic                 ev_valid_q;
	logic [PAGE_BITS-1:0] ev_page_q;
	logic [OCC_W-1:0]     occ_q;

	// configuration register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_entries_q <= RESET_ACTIVE;
		end else if (cfg.valid && cfg.ready) begin
			active_entries_q <= cfg.active_entries;
		end
	end

	// size limit clamped to 1..CAPACITY
	always_comb begin
		if (active_entries_q == '0) begin
			limit = CW'(1);
		end else if (AW'(active_entries_q) > AW'(CAPACITY)) begin
			limit = CW'(CAPACITY);
		end else begin
			limit = CW'(active_entries_q);
		end
	end

	assign full   = (count_q >= limit);
	assign stop   = full ? (count_q - CW'(1)) : count_q;
	assign accept = fetch.valid && fetch.ready;
	assign hit_c  = |cell_match;
	assign ctrl   = '{step: accept, hit: hit_c};

	assign fetch.ready = !out_valid_q || result.ready;

	assign clear_chain[0] = 1'b1;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                 pv;
		logic [PAGE_BITS-1:0] pt;
		if (i == 0) begin : g_head
			assign pv = 1'b1;
			assign pt = fetch.page_number;
		end else begin : g_body
			assign pv = cell_valid[i-1];
			assign pt = cell_tag[i-1];
		end
		lpt_cell #(
			.PAGE_BITS (PAGE_BITS),
			.CW        (CW),
			.IDX       (CW'(i))
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.page        (fetch.page_number),
			.stop        (stop),
			.prev_valid  (pv),
			.prev_tag    (pt),
			.clear_above (clear_chain[i]),
			.valid       (cell_valid[i]),
			.tag         (cell_tag[i]),
			.match       (cell_match[i]),
			.clear_below (clear_chain[i+1])
		);
	end

	assign count_next = (!hit_c && !full) ? (count_q + CW'(1)) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_next;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload; the LRU page sits in the last resident cell
	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q      <= hit_c;
			ev_valid_q <= !hit_c && full;
			ev_page_q  <= (!hit_c && full) ? cell_tag[IW'(count_q - CW'(1))] : '0;
			occ_q      <= OCC_W'(count_next);
		end
	end

	assign result.valid         = out_valid_q;
	assign result.hit           = hit_q;
	assign result.evicted_valid = ev_valid_q;
	assign result.evicted_page  = ev_page_q;
	assign result.occupancy     = occ_q;

	`LPT_ASSERT_ALWAYS(a_valid_packed, $countones(cell_valid) == int'(count_q))
	`LPT_ASSERT_ALWAYS(a_hit_no_evict, !(out_valid_q && hit_q && ev_valid_q))
	`LPT_ASSERT_NEXT(a_fill_grows, accept && !hit_c && !full, count_q == $past(count_q) + CW'(1))
	`LPT_ASSERT_NEXT(a_hit_keeps, accept && hit_c, $stable(count_q))

endmodule

>>> tb/lru_page_tracker_checker.sv
// Checker for the LRU page tracker: tracks residency and recency, compares every result.
module lru_page_tracker_checker import lpt_pkg::*; #(
	parameter int CAPACITY = 16,
	parameter int PAGE_BITS = 20
) (
	input  logic   clk,
	input  logic   arst_n,
	lpt_fetch_if   fetch,
	lpt_result_if  result,
	lpt_cfg_if     cfg,
	output int     mismatches,
	output int     pending,
	output int     results_seen,
	output int     hits_seen,
	output int     evictions_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANK_W = $clog2(CAPACITY);
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic                 hit;
		logic                 evicted_valid;
		logic [PAGE_BITS-1:0] evicted_page;
		logic [OCC_W-1:0]     occupancy;
	} page_outcome_t;

	logic [PAGE_BITS-1:0] tag_q      [CAPACITY];
	logic                 resident_q [CAPACITY];
	logic [RANK_W-1:0]    rank_q     [CAPACITY];
	logic [OCC_W-1:0]     count_q;
	logic [CFG_W-1:0]     active_q;
	page_outcome_t        outcome_q [$];

	// 0 behaves as 1, anything above the tracker depth as the full depth
	function automatic int size_limit();
		int n;
		n = int'(active_q);
		if (n == 0)
			n = 1;
		if (n > CAPACITY)
			n = CAPACITY;
		return n;
	endfunction

	function automatic page_outcome_t track_fetch(input logic [PAGE_BITS-1:0] page);
		page_outcome_t o;
		int found;
		int slot;
		o = '0;
		found = -1;
		slot = -1;
		for (int i = 0; i < CAPACITY; i++) begin
			if (found < 0 && resident_q[i] && tag_q[i] == page)
				found = i;
		end
		if (found >= 0) begin
			// entries more recent than the hit slide back one place
			for (int i = 0; i < CAPACITY; i++) begin
				if (resident_q[i] && rank_q[i] < rank_q[found])
					rank_q[i]++;
			end
			rank_q[found] = '0;
			o.hit = 1'b1;
		end else begin
			if (count_q >= size_limit()) begin
				for (int i = 0; i < CAPACITY; i++) begin
					if (resident_q[i] && (slot < 0 || rank_q[i] >= rank_q[slot]))
						slot = i;
				end
				if (slot >= 0) begin
					o.evicted_valid = 1'b1;
					o.evicted_page = tag_q[slot];
					resident_q[slot] = 1'b0;
					count_q--;
				end
			end
			if (slot < 0) begin
				for (int i = 0; i < CAPACITY; i++) begin
					if (slot < 0 && !resident_q[i])
						slot = i;
				end
			end
			if (slot >= 0) begin
				for (int i = 0; i < CAPACITY; i++) begin
					if (resident_q[i])
						rank_q[i]++;
				end
				tag_q[slot] = page;
				resident_q[slot] = 1'b1;
				rank_q[slot] = '0;
				count_q++;
			end
		end
		o.occupancy = count_q;
		return o;
	endfunction

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0t: %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		page_outcome_t seen;
		page_outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++) begin
				tag_q[i] = '0;
				resident_q[i] = 1'b0;
				rank_q[i] = '0;
			end
			count_q = '0;
			active_q = RESET_ACTIVE;
			outcome_q.delete();
		end else begin
			// result first: a result never belongs to a request taken at the same edge
			if (result.valid && result.ready) begin
				seen = {result.hit, result.evicted_valid, result.evicted_page, result.occupancy};
				results_seen++;
				if (outcome_q.size() == 0) begin
					report($sformatf("unexpected result hit=%b ev=%b page=%h occ=%0d",
						seen.hit, seen.evicted_valid, seen.evicted_page, seen.occupancy));
				end else begin
					want = outcome_q.pop_front();
					if (want.hit)
						hits_seen++;
					if (want.evicted_valid)
						evictions_seen++;
					if (seen !== want)
						report($sformatf({"result #%0d: expected hit=%b ev=%b page=%h occ=%0d,",
							" got hit=%b ev=%b page=%h occ=%0d"}, results_seen,
							want.hit, want.evicted_valid, want.evicted_page, want.occupancy,
							seen.hit, seen.evicted_valid, seen.evicted_page, seen.occupancy));
				end
			end
			if (fetch.valid && fetch.ready)
				outcome_q.push_back(track_fetch(fetch.page_number));
			if (cfg.valid && cfg.ready)
				active_q = cfg.active_entries;
		end
		pending = outcome_q.size();
	end

endmodule

>>> tb/lru_page_tracker_tb.sv
// Top of the LRU page tracker testbench: clock, reset, request traffic, result pacing, verdict.
module lru_page_tracker_tb import lpt_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY = 16;
	localparam int PAGE_BITS = 20;
	localparam int PAGE_MAX = (1 << PAGE_BITS) - 1;
	localparam int POOL_SIZE = 24;
	localparam int PHASES = 13;
	localparam int PHASE_ITEMS = 100;
	localparam int RX_HOLD = 60;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n;

	int mismatches;
	int pending;
	int results_seen;
	int hits_seen;
	int evictions_seen;
	int requests_sent;
	int settings_written;
	int cycles;

	int                   hold_requests;
	logic [PAGE_BITS-1:0] last_page;
	logic [PAGE_BITS-1:0] page_pool [POOL_SIZE];

	lpt_fetch_if #(.PAGE_BITS(PAGE_BITS)) fetch_ch ();
	lpt_result_if #(.PAGE_BITS(PAGE_BITS)) result_ch ();
	lpt_cfg_if cfg_ch ();

	lru_page_tracker #(
		.CAPACITY(CAPACITY),
		.PAGE_BITS(PAGE_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.fetch(fetch_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	lru_page_tracker_checker #(
		.CAPACITY(CAPACITY),
		.PAGE_BITS(PAGE_BITS)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.fetch(fetch_ch),
		.result(result_ch),
		.cfg(cfg_ch),
		.mismatches(mismatches),
		.pending(pending),
		.results_seen(results_seen),
		.hits_seen(hits_seen),
		.evictions_seen(evictions_seen)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("lru_page_tracker: mismatch");
			$finish;
		end
	end

	function automatic int sender_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// mostly pages from a working set a little larger than the tracker size
	function automatic logic [PAGE_BITS-1:0] pick_page(input int span);
		int pick;
		int b;
		pick = $urandom_range(0, 99);
		b = $urandom_range(0, PAGE_BITS - 1);
		if (pick < 65)
			return page_pool[$urandom_range(0, span)];
		if (pick < 78)
			return last_page;
		if (pick < 90)
			return PAGE_BITS'($urandom_range(0, PAGE_MAX));
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return PAGE_BITS'(1) << b;
			default: return ~(PAGE_BITS'(1) << b);
		endcase
	endfunction

	// entered and left at a falling edge; valid stays up for back-to-back requests
	task automatic fetch_page(input logic [PAGE_BITS-1:0] page, input int gap);
		if (gap > 0) begin
			fetch_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		fetch_ch.valid = 1'b1;
		fetch_ch.page_number = page;
		@(posedge clk);
		while (!fetch_ch.ready)
			@(posedge clk);
		@(negedge clk);
		requests_sent++;
		last_page = page;
	endtask

	task automatic write_active_size(input logic [CFG_W-1:0] value);
		fetch_ch.valid = 1'b0;
		wait (pending == 0);
		repeat (2) @(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.active_entries = value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
		settings_written++;
	endtask

	initial begin : result_pacing
		int len;
		int pick;
		int holds_done;
		holds_done = 0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_requests > holds_done) begin
				holds_done++;
				result_ch.ready = 1'b0;
				repeat (RX_HOLD) @(negedge clk);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					result_ch.ready = 1'b1;
					len = $urandom_range(1, 8);
				end else if (pick < 85) begin
					result_ch.ready = 1'b0;
					len = $urandom_range(1, 3);
				end else if (pick < 92) begin
					result_ch.ready = 1'b0;
					len = $urandom_range(6, 25);
				end else begin
					result_ch.ready = 1'b1;
					len = $urandom_range(20, 60);
				end
				repeat (len) @(negedge clk);
			end
		end
	end

	initial begin : stimulus
		logic [PAGE_BITS-1:0] opening [14];
		logic [PAGE_BITS-1:0] shrunk [4];
		logic [PAGE_BITS-1:0] widened [4];
		logic [CFG_W-1:0]     size_plan [PHASES];
		logic [CFG_W-1:0]     size_now;
		int                   eff;
		int                   span;
		bit                   no_gaps;

		// fill past the reset size of 10, evicting the second page, then hit the least recent page
		opening = '{20'h00000, 20'hFFFFF, 20'h00000, 20'h00000, 20'd1, 20'd2, 20'd3,
			20'd4, 20'd5, 20'd6, 20'd7, 20'd8, 20'd9, 20'h00000};
		shrunk = '{20'd5, 20'd100, 20'd200, 20'd200};
		widened = '{20'hABCDE, 20'h12345, 20'h00000, 20'hFFFFF};
		size_plan = '{5'd16, 5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd4, 5'd8, 5'd2, 5'd15,
			5'd12, 5'd3, 5'd10};

		arst_n = 1'b0;
		hold_requests = 0;
		last_page = '0;
		fetch_ch.valid = 1'b0;
		fetch_ch.page_number = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.active_entries = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (opening[i])
			fetch_page(opening[i], sender_gap());
		// size 0 while ten pages are resident: misses swap one page, occupancy holds
		write_active_size(5'd0);
		foreach (shrunk[i])
			fetch_page(shrunk[i], sender_gap());
		write_active_size(5'd31);
		foreach (widened[i])
			fetch_page(widened[i], sender_gap());

		for (int ph = 0; ph < PHASES; ph++) begin
			size_now = (ph == 10) ? CFG_W'($urandom_range(1, CAPACITY)) : size_plan[ph];
			write_active_size(size_now);
			eff = (size_now == 0) ? 1 : (size_now > CAPACITY) ? CAPACITY : size_now;
			span = (eff + 4 < POOL_SIZE) ? eff + 4 : POOL_SIZE - 1;
			foreach (page_pool[k])
				page_pool[k] = PAGE_BITS'($urandom_range(0, PAGE_MAX));
			no_gaps = (ph == 2) || ($urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// receiver stalls long while requests keep coming, filling the block
				if (ph == 2 && n == 30)
					hold_requests++;
				// sender drains everything outstanding mid-phase
				if (ph == 6 && n == 50) begin
					fetch_ch.valid = 1'b0;
					wait (pending == 0);
					@(negedge clk);
				end
				fetch_page(pick_page(span), no_gaps ? 0 : sender_gap());
			end
		end

		fetch_ch.valid = 1'b0;
		wait (pending == 0);
		repeat (8) @(posedge clk);
		$display("checked %0d page requests: %0d hits, %0d evictions", results_seen,
			hits_seen, evictions_seen);
		$display("%0d tracker size settings applied, sizes 0, 1, 16 and 31 among them",
			settings_written);
		if (mismatches == 0)
			$display("lru_page_tracker: match");
		else
			$display("lru_page_tracker: mismatch");
		$finish;
	end

endmodule
